[hw/rtl/crt_pair_combiner_core_defines.svh]
// Assertion macros for the checker file of the pair combiner.
// Each macro expects signals named clock and reset in the enclosing scope.
`ifndef CRT_PAIR_COMBINER_CORE_DEFINES_SVH
`define CRT_PAIR_COMBINER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define CRT_PC_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define CRT_PC_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hw/rtl/crt_pc_pkg.sv]
// Package for the pair combiner: widths, payload structs and the command
// and result structs of the shared divide/multiply unit. No dependencies.
package crt_pc_pkg;

   localparam int MODULUS_BITS = 32;
   localparam int WIDE_BITS    = 2 * MODULUS_BITS;
   localparam int STEP_BITS    = $clog2(WIDE_BITS);

   typedef struct packed {
      logic [MODULUS_BITS-1:0] residue_one;
      logic [MODULUS_BITS-1:0] modulus_one;
      logic [MODULUS_BITS-1:0] residue_two;
      logic [MODULUS_BITS-1:0] modulus_two;
   } req_type;

   typedef struct packed {
      logic [WIDE_BITS-1:0] solution;
      logic [WIDE_BITS-1:0] combined_modulus;
      logic                 solvable;
   } rsp_type;

   typedef enum logic {
      UNIT_DIV,
      UNIT_MUL
   } unit_mode_type;

   typedef struct packed {
      logic                    start;
      unit_mode_type           mode;
      logic                    wide_steps;
      logic [WIDE_BITS-1:0]    dividend;
      logic [MODULUS_BITS-1:0] divisor;
      logic [WIDE_BITS-1:0]    mcand;
   } unit_cmd_type;

   typedef struct packed {
      logic                    done;
      logic [WIDE_BITS-1:0]    quotient;
      logic [MODULUS_BITS-1:0] remainder;
      logic [WIDE_BITS-1:0]    product;
   } unit_rsp_type;

endpackage

[hw/rtl/crt_pc_divmul_unit.sv]
// Shared bit-serial unit: restoring divider and shift-add multiplier.
// Uses crt_pc_pkg for widths and the command/result structs.
module crt_pc_divmul_unit (
   input  logic                      clock,
   input  logic                      reset,
   input  crt_pc_pkg::unit_cmd_type  cmd,
   output crt_pc_pkg::unit_rsp_type  result
);

   localparam int W  = crt_pc_pkg::MODULUS_BITS;
   localparam int WW = crt_pc_pkg::WIDE_BITS;
   localparam int SB = crt_pc_pkg::STEP_BITS;

   logic                      busy_ff, busy_in;
   logic                      done_ff, done_in;
   logic [SB-1:0]             cnt_ff, cnt_in;
   logic [WW-1:0]             shreg_ff, shreg_in;
   logic [W-1:0]              rem_ff, rem_in;
   logic [WW-1:0]             quo_ff, quo_in;
   logic [WW-1:0]             acc_ff, acc_in;
   logic [W-1:0]              divisor_ff, divisor_in;
   logic [WW-1:0]             mcand_ff, mcand_in;
   crt_pc_pkg::unit_mode_type mode_ff, mode_in;

   logic       bit_out;
   logic [W:0] trial;
   logic       ge;
   logic       acc_bit;

   // The dividend register doubles as the multiplier, MSB first, so the
   // product accumulates as acc = 2*acc + bit*mcand in either mode. In
   // divide mode the bit is the new quotient bit, giving quotient*mcand.
   always_comb begin
      bit_out = shreg_ff[WW-1];
      trial   = {rem_ff, bit_out};
      ge      = (trial >= {1'b0, divisor_ff});
      acc_bit = (mode_ff == crt_pc_pkg::UNIT_DIV) ? ge : bit_out;

      busy_in    = busy_ff;
      done_in    = 1'b0;
      cnt_in     = cnt_ff;
      shreg_in   = shreg_ff;
      rem_in     = rem_ff;
      quo_in     = quo_ff;
      acc_in     = acc_ff;
      divisor_in = divisor_ff;
      mcand_in   = mcand_ff;
      mode_in    = mode_ff;

      if (cmd.start) begin
         busy_in    = 1'b1;
         mode_in    = cmd.mode;
         divisor_in = cmd.divisor;
         mcand_in   = cmd.mcand;
         rem_in     = '0;
         quo_in     = '0;
         acc_in     = '0;
         if (cmd.wide_steps) begin
            shreg_in = cmd.dividend;
            cnt_in   = SB'(WW - 1);
         end else begin
            shreg_in = {cmd.dividend[W-1:0], {(WW-W){1'b0}}};
            cnt_in   = SB'(W - 1);
         end
      end else if (busy_ff) begin
         shreg_in = {shreg_ff[WW-2:0], 1'b0};
         rem_in   = ge ? W'(trial - {1'b0, divisor_ff}) : trial[W-1:0];
         quo_in   = {quo_ff[WW-2:0], ge};
         acc_in   = {acc_ff[WW-2:0], 1'b0} + (acc_bit ? mcand_ff : '0);
         cnt_in   = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff     <= cnt_in;
      shreg_ff   <= shreg_in;
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      acc_ff     <= acc_in;
      divisor_ff <= divisor_in;
      mcand_ff   <= mcand_in;
      mode_ff    <= mode_in;
   end

   assign result.done      = done_ff;
   assign result.quotient  = quo_ff;
   assign result.remainder = rem_ff;
   assign result.product   = acc_ff;

endmodule

[hw/rtl/crt_pair_combiner_core.sv]
// Combines x = r1 mod n1 and x = r2 mod n2 (moduli need not be coprime) into
// the least solution modulo lcm(n1, n2), or flags the pair as unsolvable.
// A sequencer drives one bit-serial divide/multiply unit: every division or
// product is one unit pass, the 64-bit reduction a pass of wide steps. A zero
// modulus goes straight to the output, and an inconsistent pair stops right
// after the residue check. Ready is high only while the sequencer idles; a
// finished result waits in an output register without blocking new input,
// and only a result that finds that register still full waits for it.
module crt_pair_combiner_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  crt_pc_pkg::req_type req_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output crt_pc_pkg::rsp_type rsp_data
);

   localparam int W  = crt_pc_pkg::MODULUS_BITS;
   localparam int WW = crt_pc_pkg::WIDE_BITS;

   typedef enum logic [4:0] {
      ST_IDLE, ST_RED1, ST_RED2, ST_GCD, ST_MODG1, ST_MODG2, ST_DIVA, ST_DIVB,
      ST_LCM, ST_R1N2, ST_DIVC, ST_AMODB, ST_EUCL, ST_INVFIX, ST_KMUL, ST_KMOD,
      ST_XMUL, ST_OUT
   } state_type;

   state_type state_ff, state_in;
   logic      launched_ff, launched_in;
   logic      ok_ff, ok_in;
   logic [W-1:0] r1_ff, r1_in, n1_ff, n1_in, r2_ff, r2_in, n2_ff, n2_in;
   logic [W-1:0] p_ff, p_in, q_ff, q_in, g_ff, g_in, e1_ff, e1_in;
   logic [W-1:0] a_ff, a_in, b_ff, b_in, c_ff, c_in, inv_ff, inv_in, k_ff, k_in;
   logic signed [W+1:0] t0_ff, t0_in, t1_ff, t1_in;
   logic [WW-1:0] lcm_ff, lcm_in, wide_ff, wide_in;
   logic          rsp_valid_ff, rsp_valid_in;
   crt_pc_pkg::rsp_type rsp_data_ff, rsp_data_in;

   crt_pc_pkg::unit_cmd_type cmd;
   crt_pc_pkg::unit_rsp_type ures;

   logic                go, fin;
   logic [W:0]          diff_sum;
   logic [WW-1:0]       coef_full;
   logic signed [W+1:0] fix_v;
   logic [W:0]          fix_sub;

   crt_pc_divmul_unit u_unit (
      .clock  (clock),
      .reset  (reset),
      .cmd    (cmd),
      .result (ures)
   );

   always_comb begin
      go  = !launched_ff;
      fin = launched_ff && ures.done;

      diff_sum  = {1'b0, r2_ff} + {1'b0, n2_ff} - {1'b0, ures.remainder};
      coef_full = {{(WW-W-2){t0_ff[W+1]}}, t0_ff} - ures.product;
      fix_v     = t0_ff[W+1] ? (t0_ff + $signed({2'b00, b_ff})) : t0_ff;
      fix_sub   = fix_v[W:0] - {1'b0, b_ff};

      state_in     = state_ff;
      ok_in        = ok_ff;
      r1_in = r1_ff; n1_in = n1_ff; r2_in = r2_ff; n2_in = n2_ff;
      p_in  = p_ff;  q_in  = q_ff;  g_in  = g_ff;  e1_in = e1_ff;
      a_in  = a_ff;  b_in  = b_ff;  c_in  = c_ff;  inv_in = inv_ff; k_in = k_ff;
      t0_in = t0_ff; t1_in = t1_ff;
      lcm_in  = lcm_ff;
      wide_in = wide_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      cmd       = '0;
      cmd.mode  = crt_pc_pkg::UNIT_DIV;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               r1_in = req_data.residue_one;
               n1_in = req_data.modulus_one;
               r2_in = req_data.residue_two;
               n2_in = req_data.modulus_two;
               ok_in = 1'b1;
               if (req_data.modulus_one == '0 || req_data.modulus_two == '0) begin
                  ok_in    = 1'b0;
                  state_in = ST_OUT;
               end else begin
                  state_in = ST_RED1;
               end
            end
         end
         ST_RED1: begin
            cmd.start    = go;
            cmd.dividend = {{(WW-W){1'b0}}, r1_ff};
            cmd.divisor  = n1_ff;
            if (fin) begin
               r1_in    = ures.remainder;
               state_in = ST_RED2;
            end
         end
         ST_RED2: begin
            cmd.start    = go;
            cmd.dividend = {{(WW-W){1'b0}}, r2_ff};
            cmd.divisor  = n2_ff;
            if (fin) begin
               r2_in    = ures.remainder;
               p_in     = n1_ff;
               q_in     = n2_ff;
               state_in = ST_GCD;
            end
         end
         ST_GCD: begin
            if (q_ff == '0) begin
               g_in     = p_ff;
               state_in = ST_MODG1;
            end else begin
               cmd.start    = go;
               cmd.dividend = {{(WW-W){1'b0}}, p_ff};
               cmd.divisor  = q_ff;
               if (fin) begin
                  p_in = q_ff;
                  q_in = ures.remainder;
               end
            end
         end
         ST_MODG1: begin
            cmd.start    = go;
            cmd.dividend = {{(WW-W){1'b0}}, r1_ff};
            cmd.divisor  = g_ff;
            if (fin) begin
               e1_in    = ures.remainder;
               state_in = ST_MODG2;
            end
         end
         ST_MODG2: begin
            cmd.start    = go;
            cmd.dividend = {{(WW-W){1'b0}}, r2_ff};
            cmd.divisor  = g_ff;
            if (fin) begin
               if (ures.remainder != e1_ff) begin
                  ok_in    = 1'b0;
                  state_in = ST_OUT;
               end else begin
                  state_in = ST_DIVA;
               end
            end
         end
         ST_DIVA: begin
            cmd.start    = go;
            cmd.dividend = {{(WW-W){1'b0}}, n1_ff};
            cmd.divisor  = g_ff;
            if (fin) begin
               a_in     = ures.quotient[W-1:0];
               state_in = ST_DIVB;
            end
         end
         ST_DIVB: begin
            cmd.start    = go;
            cmd.dividend = {{(WW-W){1'b0}}, n2_ff};
            cmd.divisor  = g_ff;
            if (fin) begin
               b_in     = ures.quotient[W-1:0];
               state_in = ST_LCM;
            end
         end
         ST_LCM: begin
            cmd.start    = go;
            cmd.mode     = crt_pc_pkg::UNIT_MUL;
            cmd.dividend = {{(WW-W){1'b0}}, n2_ff};
            cmd.mcand    = {{(WW-W){1'b0}}, a_ff};
            if (fin) begin
               lcm_in   = ures.product;
               state_in = ST_R1N2;
            end
         end
         ST_R1N2: begin
            cmd.start    = go;
            cmd.dividend = {{(WW-W){1'b0}}, r1_ff};
            cmd.divisor  = n2_ff;
            if (fin) begin
               // Difference of the residues, brought back into [0, n2).
               if (r2_ff >= ures.remainder) begin
                  e1_in = r2_ff - ures.remainder;
               end else begin
                  e1_in = diff_sum[W-1:0];
               end
               state_in = ST_DIVC;
            end
         end
         ST_DIVC: begin
            cmd.start    = go;
            cmd.dividend = {{(WW-W){1'b0}}, e1_ff};
            cmd.divisor  = g_ff;
            if (fin) begin
               c_in     = ures.quotient[W-1:0];
               state_in = ST_AMODB;
            end
         end
         ST_AMODB: begin
            cmd.start    = go;
            cmd.dividend = {{(WW-W){1'b0}}, a_ff};
            cmd.divisor  = b_ff;
            if (fin) begin
               p_in     = b_ff;
               q_in     = ures.remainder;
               t0_in    = '0;
               t1_in    = (W+2)'(1);
               state_in = ST_EUCL;
            end
         end
         ST_EUCL: begin
            if (q_ff == '0) begin
               state_in = ST_INVFIX;
            end else begin
               // The unit returns the quotient times t1 alongside the division.
               cmd.start    = go;
               cmd.dividend = {{(WW-W){1'b0}}, p_ff};
               cmd.divisor  = q_ff;
               cmd.mcand    = {{(WW-W-2){t1_ff[W+1]}}, t1_ff};
               if (fin) begin
                  p_in  = q_ff;
                  q_in  = ures.remainder;
                  t0_in = t1_ff;
                  t1_in = $signed(coef_full[W+1:0]);
               end
            end
         end
         ST_INVFIX: begin
            if (fix_v[W:0] >= {1'b0, b_ff}) begin
               inv_in = fix_sub[W-1:0];
            end else begin
               inv_in = fix_v[W-1:0];
            end
            state_in = ST_KMUL;
         end
         ST_KMUL: begin
            cmd.start    = go;
            cmd.mode     = crt_pc_pkg::UNIT_MUL;
            cmd.dividend = {{(WW-W){1'b0}}, inv_ff};
            cmd.mcand    = {{(WW-W){1'b0}}, c_ff};
            if (fin) begin
               wide_in  = ures.product;
               state_in = ST_KMOD;
            end
         end
         ST_KMOD: begin
            cmd.start      = go;
            cmd.wide_steps = 1'b1;
            cmd.dividend   = wide_ff;
            cmd.divisor    = b_ff;
            if (fin) begin
               k_in     = ures.remainder;
               state_in = ST_XMUL;
            end
         end
         ST_XMUL: begin
            cmd.start    = go;
            cmd.mode     = crt_pc_pkg::UNIT_MUL;
            cmd.dividend = {{(WW-W){1'b0}}, n1_ff};
            cmd.mcand    = {{(WW-W){1'b0}}, k_ff};
            if (fin) begin
               wide_in  = ures.product + {{(WW-W){1'b0}}, r1_ff};
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               if (ok_ff) begin
                  rsp_data_in.solution         = wide_ff;
                  rsp_data_in.combined_modulus = lcm_ff;
                  rsp_data_in.solvable         = 1'b1;
               end else begin
                  rsp_data_in = '0;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      launched_in = cmd.start || (launched_ff && !ures.done);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         launched_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         launched_ff  <= launched_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      ok_ff <= ok_in;
      r1_ff <= r1_in; n1_ff <= n1_in; r2_ff <= r2_in; n2_ff <= n2_in;
      p_ff  <= p_in;  q_ff  <= q_in;  g_ff  <= g_in;  e1_ff <= e1_in;
      a_ff  <= a_in;  b_ff  <= b_in;  c_ff  <= c_in;  inv_ff <= inv_in;
      k_ff  <= k_in;
      t0_ff <= t0_in; t1_ff <= t1_in;
      lcm_ff      <= lcm_in;
      wide_ff     <= wide_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

[hw/rtl/crt_pc_checker.sv]
// Port-level checks for the pair combiner, bound to its top level.
// Uses crt_pc_pkg types and the macros of crt_pair_combiner_core_defines.svh.
`include "crt_pair_combiner_core_defines.svh"

module crt_pc_checker (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_ready,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input crt_pc_pkg::rsp_type rsp_data
);

   // A waiting result must hold until its transfer.
   `CRT_PC_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data), "result changed while stalled")

   // Ready drops in the cycle after an input transfer.
   `CRT_PC_ASSERT_NEXT(a_busy_after_req, req_valid && req_ready, !req_ready, "ready right after a transfer")

   `CRT_PC_ASSERT_NOW(a_fail_zero, rsp_valid && !rsp_data.solvable, rsp_data.solution == '0 && rsp_data.combined_modulus == '0, "unsolvable result carries data")

   `CRT_PC_ASSERT_NOW(a_sol_range, rsp_valid && rsp_data.solvable, rsp_data.solution < rsp_data.combined_modulus, "solution not below lcm")

endmodule

bind crt_pair_combiner_core crt_pc_checker u_crt_pc_checker (.*);

[test/tb_crt_pair_combiner_core.sv]
// Testbench for crt_pair_combiner_core: drives congruence pairs through the
// request channel and checks each response against a built-in CRT predictor.
// Depends on crt_pc_pkg and the crt_pair_combiner_core RTL.
module tb_crt_pair_combiner_core;

   localparam longint CYCLE_LIMIT = 64'd20000000;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_ready;
   crt_pc_pkg::req_type req_data;
   logic                rsp_valid;
   logic                rsp_ready;
   crt_pc_pkg::rsp_type rsp_data;

   crt_pc_pkg::rsp_type expected_solutions[$];
   int      error_count;
   longint  cycle_count;
   int      sender_idle_pct;
   int      receiver_idle_pct;

   crt_pair_combiner_core u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Greatest common divisor by repeated remainder.
   function automatic logic [63:0] gcd_of(logic [63:0] p, logic [63:0] q);
      logic [63:0] t;
      while (q != 0) begin
         t = p % q;
         p = q;
         q = t;
      end
      return p;
   endfunction

   // Inverse of a modulo m by extended Euclid, with signed coefficients.
   function automatic logic [63:0] inverse_of(logic [63:0] a, logic [63:0] m);
      longint r0, r1, t0, t1, q, nr, nt;
      r0 = m;
      r1 = a % m;
      t0 = 0;
      t1 = 1;
      while (r1 != 0) begin
         q = r0 / r1;
         nr = r0 - q * r1;
         nt = t0 - q * t1;
         r0 = r1;
         r1 = nr;
         t0 = t1;
         t1 = nt;
      end
      if (t0 < 0) t0 += m;
      return 64'(t0) % m;
   endfunction

   function automatic crt_pc_pkg::rsp_type combine_pair(crt_pc_pkg::req_type item);
      crt_pc_pkg::rsp_type res;
      logic [63:0] r1, n1, r2, n2, g, a, b, t, c, inv, k0;
      logic [127:0] prod;
      res = '0;
      r1 = item.residue_one;
      n1 = item.modulus_one;
      r2 = item.residue_two;
      n2 = item.modulus_two;
      if (n1 == 0 || n2 == 0) return res;
      r1 = r1 % n1;
      r2 = r2 % n2;
      g = gcd_of(n1, n2);
      if ((r1 % g) != (r2 % g)) return res;
      a = n1 / g;
      b = n2 / g;
      t = (r2 + n2 - (r1 % n2)) % n2;
      c = t / g;
      inv = inverse_of(a, b);
      prod = 128'(c) * 128'(inv);
      k0 = 64'(prod % 128'(b));
      res.solution = r1 + k0 * n1;
      res.combined_modulus = a * n2;
      res.solvable = 1'b1;
      return res;
   endfunction

   // Valid stays high from one transfer to the next unless the sender idles.
   task automatic send_pair(crt_pc_pkg::req_type item);
      while ($urandom_range(99, 0) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      expected_solutions.push_back(combine_pair(item));
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic send_fields(logic [31:0] r1, logic [31:0] n1, logic [31:0] r2,
                              logic [31:0] n2);
      crt_pc_pkg::req_type item;
      item.residue_one = r1;
      item.modulus_one = n1;
      item.residue_two = r2;
      item.modulus_two = n2;
      send_pair(item);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (expected_solutions.size() != 0) @(posedge clock);
   endtask

   // Receiver stalls at random; every transfer is checked against the oldest
   // expectation.
   always @(posedge clock) begin
      crt_pc_pkg::rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_solutions.size() == 0) begin
               $display("%0t: unexpected response %h", $time, rsp_data);
               error_count++;
            end else begin
               want = expected_solutions.pop_front();
               if (rsp_data.solution !== want.solution) begin
                  $display("%0t: solution expected %h actual %h", $time,
                           want.solution, rsp_data.solution);
                  error_count++;
               end
               if (rsp_data.combined_modulus !== want.combined_modulus) begin
                  $display("%0t: combined_modulus expected %h actual %h", $time,
                           want.combined_modulus, rsp_data.combined_modulus);
                  error_count++;
               end
               if (rsp_data.solvable !== want.solvable) begin
                  $display("%0t: solvable expected %b actual %b", $time,
                           want.solvable, rsp_data.solvable);
                  error_count++;
               end
            end
         end
         rsp_ready <= ($urandom_range(99, 0) >= receiver_idle_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   task automatic test_directed();
      send_fields(32'd2, 32'd3, 32'd3, 32'd5);
      send_fields(32'd1, 32'd4, 32'd3, 32'd6);
      send_fields(32'd1, 32'd4, 32'd2, 32'd6);
      send_fields(32'd0, 32'd0, 32'd0, 32'd5);
      send_fields(32'd7, 32'd5, 32'd0, 32'd0);
      send_fields(32'd0, 32'd1, 32'd0, 32'd1);
      send_fields('1, '1, '1, '1);
      send_fields('1, '1, 32'd0, 32'hFFFF_FFFE);
      send_fields(32'd100, 32'd7, 32'd55, 32'd9);
      send_fields(32'd5, 32'd12, 32'd5, 32'd12);
      send_fields(32'd5, 32'd12, 32'd6, 32'd12);
      send_fields(32'h8000_0000, 32'hFFFF_FFFB, 32'd3, 32'hFFFF_FFF1);
      send_fields(32'd0, 32'h8000_0000, 32'h1234_5678, 32'd1);
      send_fields(32'hAAAA_AAAA, 32'h5555_5555, 32'h5555_5555, 32'hAAAA_AAAA);
      // Hold off until the block has returned everything sent so far.
      wait_drained();
      send_fields(32'd3, 32'd60, 32'd13, 32'd100);
   endtask

   function automatic logic [31:0] random_modulus();
      case ($urandom_range(5, 0))
         0: return $urandom_range(16, 0);
         1: return $urandom_range(1000, 1);
         2: return $urandom_range(1000, 1) * $urandom_range(64, 1);
         3: return 32'hFFFF_FFFF - $urandom_range(50, 0);
         default: return $urandom();
      endcase
   endfunction

   task automatic test_random(int count);
      crt_pc_pkg::req_type item;
      logic [31:0] g;
      repeat (count) begin
         item.modulus_one = random_modulus();
         item.modulus_two = random_modulus();
         item.residue_one = $urandom();
         item.residue_two = $urandom();
         // Often share a factor and pick residues that agree modulo it.
         if ($urandom_range(1, 0) == 1) begin
            g = $urandom_range(300, 1);
            item.modulus_one = g * $urandom_range(20000, 1);
            item.modulus_two = g * $urandom_range(20000, 1);
            item.residue_two = item.residue_one % g + g * $urandom_range(1000, 0);
         end
         send_pair(item);
      end
   endtask

   initial begin
      error_count = 0;
      cycle_count = 0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_ready = 1'b0;
      sender_idle_pct = 0;
      receiver_idle_pct = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      sender_idle_pct = 11;
      receiver_idle_pct = 51;
      test_directed();
      test_random(390);
      sender_idle_pct = 51;
      receiver_idle_pct = 11;
      test_random(390);
      sender_idle_pct = 0;
      receiver_idle_pct = 0;
      test_random(375);
      wait_drained();
      repeat (200) @(posedge clock);
      if (error_count == 0 && expected_solutions.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end
endmodule
